FILE: src/aswc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aswc_pkg
// Shared types and codes of the abort sequence watchdog controller.
// ----------------------------------------------------------------------------
package aswc_pkg;

  localparam int KIND_W  = 3;
  localparam int ID_W    = 8;
  localparam int STATE_W = 3;
  localparam int BITS_W  = 8;
  localparam int LIM_W   = 16;
  localparam int CNT_W   = 17;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // controller state codes
  localparam logic [STATE_W-1:0] M_WAIT      = 3'd0;
  localparam logic [STATE_W-1:0] M_ACTIVE    = 3'd1;
  localparam logic [STATE_W-1:0] M_STD_ABORT = 3'd2;
  localparam logic [STATE_W-1:0] M_NC_ABORT  = 3'd3;
  localparam logic [STATE_W-1:0] M_FINISHED  = 3'd4;
  localparam logic [STATE_W-1:0] M_CONN_LOSS = 3'd5;

  // event kinds
  localparam logic [KIND_W-1:0] EV_TICK      = 3'd0;
  localparam logic [KIND_W-1:0] EV_HEARTBEAT = 3'd1;
  localparam logic [KIND_W-1:0] EV_CONFIG    = 3'd2;
  localparam logic [KIND_W-1:0] EV_ABORT     = 3'd3;
  localparam logic [KIND_W-1:0] EV_ABORT_END = 3'd4;
  localparam logic [KIND_W-1:0] EV_CLEAR     = 3'd5;
  localparam logic [KIND_W-1:0] EV_COMMAND   = 3'd6;

  // register indexes
  localparam logic [1:0] REG_HB_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_LOSS_GRACE = 2'd1;
  localparam logic [1:0] REG_NC_HOLD    = 2'd2;

  localparam logic [LIM_W-1:0] HB_TIMEOUT_RST = 16'd3000;
  localparam logic [LIM_W-1:0] LOSS_GRACE_RST = 16'd5000;
  localparam logic [LIM_W-1:0] NC_HOLD_RST    = 16'd10000;

  typedef struct packed {
    logic [LIM_W-1:0] hb_timeout;
    logic [LIM_W-1:0] loss_grace;
    logic [LIM_W-1:0] nc_hold;
  } limits_t;

endpackage
`default_nettype wire

FILE: src/aswc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aswc_in_if
// Event channel: one event transaction with its kind and actuator command.
// ----------------------------------------------------------------------------
interface aswc_in_if;
  logic                          valid;
  logic                          ready;
  logic [aswc_pkg::KIND_W-1:0]   kind;
  logic [aswc_pkg::ID_W-1:0]     act_num;
  logic                          actuator_on;

  modport source (output valid, kind, act_num, actuator_on, input ready);
  modport sink   (input valid, kind, act_num, actuator_on, output ready);
endinterface
`default_nettype wire

FILE: src/aswc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aswc_out_if
// Result channel: controller state and actuator levels after each event.
// ----------------------------------------------------------------------------
interface aswc_out_if;
  logic                           valid;
  logic                           ready;
  logic [aswc_pkg::STATE_W-1:0]   ctrl_state;
  logic [aswc_pkg::BITS_W-1:0]    actuator_bits;
  logic                           state_changed;

  modport source (output valid, ctrl_state, actuator_bits, state_changed, input ready);
  modport sink   (input valid, ctrl_state, actuator_bits, state_changed, output ready);
endinterface
`default_nettype wire

FILE: src/aswc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aswc_cfg_regs
// APB-style register file holding the three millisecond limits.
// ----------------------------------------------------------------------------
module aswc_cfg_regs (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [aswc_pkg::ADDR_W-1:0]  paddr,
  input  wire  [aswc_pkg::DATA_W-1:0]  pwdata,
  output logic [aswc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output aswc_pkg::limits_t            limits
);

  aswc_pkg::limits_t lim_r;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];
  assign limits  = lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.hb_timeout <= aswc_pkg::HB_TIMEOUT_RST;
      lim_r.loss_grace <= aswc_pkg::LOSS_GRACE_RST;
      lim_r.nc_hold    <= aswc_pkg::NC_HOLD_RST;
    end else if (wr_en) begin
      case (reg_idx)
        aswc_pkg::REG_HB_TIMEOUT: lim_r.hb_timeout <= pwdata[aswc_pkg::LIM_W-1:0];
        aswc_pkg::REG_LOSS_GRACE: lim_r.loss_grace <= pwdata[aswc_pkg::LIM_W-1:0];
        aswc_pkg::REG_NC_HOLD:    lim_r.nc_hold    <= pwdata[aswc_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      aswc_pkg::REG_HB_TIMEOUT:
        prdata = {{(aswc_pkg::DATA_W-aswc_pkg::LIM_W){1'b0}}, lim_r.hb_timeout};
      aswc_pkg::REG_LOSS_GRACE:
        prdata = {{(aswc_pkg::DATA_W-aswc_pkg::LIM_W){1'b0}}, lim_r.loss_grace};
      aswc_pkg::REG_NC_HOLD:
        prdata = {{(aswc_pkg::DATA_W-aswc_pkg::LIM_W){1'b0}}, lim_r.nc_hold};
      default:
        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/aswc_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aswc_core
// Event register, single-pass state update and result register.
// ----------------------------------------------------------------------------
module aswc_core #(
  parameter int ACTUATOR_COUNT = 8
) (
  input  wire                clk,
  input  wire                rst_n,
  input  aswc_pkg::limits_t  limits,
  aswc_in_if.sink            in_ch,
  aswc_out_if.source         out_ch
);

  localparam int CW = aswc_pkg::CNT_W;

  // event stage
  logic                          in_v_r;
  logic [aswc_pkg::KIND_W-1:0]   kind_r;
  logic [aswc_pkg::ID_W-1:0]     id_r;
  logic                          on_r;

  // controller state
  logic [aswc_pkg::STATE_W-1:0]  mode_r, mode_nxt;
  logic                          seen_r, seen_nxt;
  logic [CW-1:0]                 age_r, age_nxt;
  logic [CW-1:0]                 tim_r, tim_nxt;
  logic [aswc_pkg::BITS_W-1:0]   lev_r, lev_nxt;

  // result stage
  logic                          out_v_r;
  logic [aswc_pkg::STATE_W-1:0]  res_state_r;
  logic [aswc_pkg::BITS_W-1:0]   res_bits_r;
  logic                          res_chg_r;

  logic                          out_adv, in_rdy, step;
  logic [aswc_pkg::STATE_W-1:0]  mode_pkt;
  logic                          lost, id_ok;
  logic [2:0]                    bit_idx;

  assign out_adv     = !out_v_r || out_ch.ready;
  assign in_rdy      = !in_v_r || out_adv;
  assign step        = in_v_r && out_adv;
  assign in_ch.ready = in_rdy;

  assign out_ch.valid         = out_v_r;
  assign out_ch.ctrl_state    = res_state_r;
  assign out_ch.actuator_bits = res_bits_r;
  assign out_ch.state_changed = res_chg_r;

  assign id_ok   = (id_r >= 8'd1) && (id_r <= 8'(ACTUATOR_COUNT));
  assign bit_idx = id_r[2:0] - 3'd1;

  always_comb begin
    age_nxt  = age_r;
    tim_nxt  = tim_r;
    seen_nxt = seen_r;
    lev_nxt  = lev_r;

    case (kind_r)
      aswc_pkg::EV_TICK: begin
        age_nxt = (age_r == aswc_pkg::CNT_MAX) ? age_r : age_r + CW'(1);
        tim_nxt = (tim_r == aswc_pkg::CNT_MAX) ? tim_r : tim_r + CW'(1);
      end
      aswc_pkg::EV_HEARTBEAT: begin
        age_nxt  = '0;
        seen_nxt = 1'b1;
      end
      aswc_pkg::EV_COMMAND: begin
        if ((mode_r inside {aswc_pkg::M_ACTIVE, aswc_pkg::M_STD_ABORT}) && id_ok) begin
          lev_nxt[bit_idx] = on_r;
        end
      end
      default: ;
    endcase

    // packet transitions
    mode_pkt = mode_r;
    case (mode_r)
      aswc_pkg::M_WAIT:
        if (kind_r == aswc_pkg::EV_CONFIG) mode_pkt = aswc_pkg::M_ACTIVE;
      aswc_pkg::M_ACTIVE:
        if (kind_r == aswc_pkg::EV_ABORT) mode_pkt = aswc_pkg::M_STD_ABORT;
      aswc_pkg::M_STD_ABORT:
        if (kind_r == aswc_pkg::EV_ABORT_END) mode_pkt = aswc_pkg::M_FINISHED;
      aswc_pkg::M_FINISHED:
        if (kind_r == aswc_pkg::EV_CLEAR) mode_pkt = aswc_pkg::M_ACTIVE;
      aswc_pkg::M_CONN_LOSS:
        if (kind_r == aswc_pkg::EV_HEARTBEAT) mode_pkt = aswc_pkg::M_ACTIVE;
      default: ;
    endcase
    if (mode_pkt != mode_r) begin
      tim_nxt = '0;
    end

    // timeout rules
    lost     = seen_nxt && (age_nxt > {1'b0, limits.hb_timeout});
    mode_nxt = mode_pkt;
    case (mode_pkt)
      aswc_pkg::M_ACTIVE:
        if (lost) mode_nxt = aswc_pkg::M_CONN_LOSS;
      aswc_pkg::M_STD_ABORT:
        if (lost) mode_nxt = aswc_pkg::M_NC_ABORT;
      aswc_pkg::M_NC_ABORT:
        if (tim_nxt >= {1'b0, limits.nc_hold}) mode_nxt = aswc_pkg::M_FINISHED;
      aswc_pkg::M_CONN_LOSS:
        if (tim_nxt >= {1'b0, limits.loss_grace}) mode_nxt = aswc_pkg::M_NC_ABORT;
      default: ;
    endcase
    if (mode_nxt != mode_pkt) begin
      tim_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      mode_r  <= aswc_pkg::M_WAIT;
      seen_r  <= 1'b0;
      age_r   <= '0;
      tim_r   <= '0;
      lev_r   <= '0;
    end else begin
      if (in_rdy) begin
        in_v_r <= in_ch.valid;
      end
      if (out_adv) begin
        out_v_r <= in_v_r;
      end
      if (step) begin
        mode_r <= mode_nxt;
        seen_r <= seen_nxt;
        age_r  <= age_nxt;
        tim_r  <= tim_nxt;
        lev_r  <= lev_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      kind_r <= in_ch.kind;
      id_r   <= in_ch.act_num;
      on_r   <= in_ch.actuator_on;
    end
    if (step) begin
      res_state_r <= mode_nxt;
      res_bits_r  <= lev_nxt;
      res_chg_r   <= (mode_nxt != mode_r);
    end
  end

endmodule
`default_nettype wire

FILE: src/abort_sequence_watchdog_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abort_sequence_watchdog_controller
// Six-state abort controller with heartbeat watchdog and actuator levels.
//
// Events enter on in_ch (valid/ready); every event transaction yields exactly
// one result transaction on out_ch with the controller state, the actuator
// on/off bits and a flag telling whether the event changed the state.
// The three millisecond limits sit behind the cfg_ APB port at byte
// addresses 0, 4 and 8; pready is tied high.
// An accepted event is held in the event register, and the single-pass state
// update then loads the result register. Throughput is one event per cycle
// while the receiver does not stall, set by that single update.
// When the receiver stalls, the result register holds and the event register
// fills; in_ch.ready drops only when both are occupied.
// Reset clears the state to waiting, both counters, the heartbeat flag and
// all actuator bits, and loads the default limits.
// ----------------------------------------------------------------------------
module abort_sequence_watchdog_controller #(
  parameter int ACTUATOR_COUNT = 8
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire  [aswc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire  [aswc_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [aswc_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready,
  aswc_in_if.sink                      in_ch,
  aswc_out_if.source                   out_ch
);

  aswc_pkg::limits_t limits;

  aswc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .limits  (limits)
  );

  aswc_core #(
    .ACTUATOR_COUNT (ACTUATOR_COUNT)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .limits (limits),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire
